[rtl/core/dq_pkg.sv]
// Shared types and codes for the double-ended queue.
// Holds operation codes, status codes and the cell command type.
package dq_pkg;

   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

   // command broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CMD_HOLD       = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_PUSH_REAR  = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_POP_REAR   = 3'd4,
      CMD_CLEAR      = 3'd5
   } cell_cmd_type;

endpackage

[rtl/core/double_ended_queue.sv]
// Double-ended queue top level: request decode, chain of dq_cell, result register.
// Depends on dq_pkg and dq_cell.
// Latency: the result of a request is offered in the cycle after it is accepted.
// Throughput: one request per cycle; a new request is taken in the cycle its
// predecessor's result is taken. Each cell shifts one step per front push or pop.
// Reset (synchronous): empties the deque and drops any pending result;
// stored words are not cleared.
module double_ended_queue #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // [2:0] operation, then data; zero filled to whole bytes
   input  logic [((dq_pkg::OP_W + DATA_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // front_value, rear_value, count, is_empty, is_full, status (low to high)
   output logic [((2 * DATA_WIDTH + $clog2(DEPTH + 1) + 2 + dq_pkg::STATUS_W + 7) / 8) * 8 - 1:0]
                rsp_tdata
);
   import dq_pkg::*;

   localparam int CW    = $clog2(DEPTH + 1);
   localparam int RSP_W = ((2 * DATA_WIDTH + CW + 2 + STATUS_W + 7) / 8) * 8;

   logic [OP_W-1:0]       op;
   logic [DATA_WIDTH-1:0] word;
   logic                  accept;
   logic                  full, empty;
   cell_cmd_type          cmd;

   logic [CW-1:0]         count_ff, count_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]      cell_valid;
   logic [DEPTH-1:0]      cell_last;
   logic [DATA_WIDTH-1:0] rear_acc;
   logic [DATA_WIDTH-1:0] front_value, rear_value;

   assign op     = req_tdata[OP_W-1:0];
   assign word   = req_tdata[OP_W +: DATA_WIDTH];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;
   assign full   = cell_valid[DEPTH-1];
   assign empty  = !cell_valid[0];

   always_comb begin
      cmd       = CMD_HOLD;
      count_in  = count_ff;
      status_in = ST_OK;
      unique case (op)
         OP_PUSH_FRONT, OP_PUSH_REAR: begin
            if (full) begin
               status_in = ST_OVERFLOW;
            end else begin
               cmd      = (op == OP_PUSH_FRONT) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
               count_in = count_ff + CW'(1);
            end
         end
         OP_POP_FRONT, OP_POP_REAR: begin
            if (empty) begin
               status_in = ST_UNDERFLOW;
            end else begin
               cmd      = (op == OP_POP_FRONT) ? CMD_POP_FRONT : CMD_POP_REAR;
               count_in = count_ff - CW'(1);
            end
         end
         OP_CLEAR: begin
            cmd      = CMD_CLEAR;
            count_in = '0;
         end
         default: begin
         end
      endcase
      if (!accept) begin
         cmd       = CMD_HOLD;
         count_in  = count_ff;
         status_in = status_ff;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ST_OK;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data, right_data;
      logic                  left_valid, right_valid;

      if (i == 0) begin : g_head
         assign left_data  = word;
         assign left_valid = 1'b1;
      end else begin : g_mid_left
         assign left_data  = cell_data[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_data  = word;
         assign right_valid = 1'b0;
      end else begin : g_mid_right
         assign right_data  = cell_data[i+1];
         assign right_valid = cell_valid[i+1];
      end

      assign cell_last[i] = cell_valid[i] && !right_valid;

      dq_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .word        (word),
         .left_data   (left_data),
         .left_valid  (left_valid),
         .right_data  (right_data),
         .right_valid (right_valid),
         .data        (cell_data[i]),
         .valid       (cell_valid[i])
      );
   end

   // rear entry is the single occupied cell whose right neighbor is free
   always_comb begin
      rear_acc = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rear_acc = rear_acc | (cell_data[i] & {DATA_WIDTH{cell_last[i]}});
      end
   end

   assign front_value = empty ? '1 : cell_data[0];
   assign rear_value  = empty ? '1 : rear_acc;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({status_ff, full, empty, count_ff, rear_value, front_value});

endmodule

[rtl/core/dq_cell.sv]
// One storage cell of the deque chain: a data word and an occupancy bit.
// Shifts with its neighbors on pushes and pops at the front.
// Depends on dq_pkg.
module dq_cell #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dq_pkg::cell_cmd_type     cmd,
   input  logic [DATA_WIDTH-1:0]    word,
   input  logic [DATA_WIDTH-1:0]    left_data,
   input  logic                     left_valid,
   input  logic [DATA_WIDTH-1:0]    right_data,
   input  logic                     right_valid,
   output logic [DATA_WIDTH-1:0]    data,
   output logic                     valid
);
   import dq_pkg::*;

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  valid_ff, valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      unique case (cmd)
         CMD_PUSH_FRONT: begin
            data_in  = left_data;
            valid_in = left_valid;
         end
         CMD_PUSH_REAR: begin
            if (left_valid && !valid_ff) begin
               data_in  = word;
               valid_in = 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            data_in  = right_data;
            valid_in = right_valid;
         end
         CMD_POP_REAR: begin
            if (valid_ff && !right_valid) begin
               valid_in = 1'b0;
            end
         end
         CMD_CLEAR: begin
            valid_in = 1'b0;
         end
         CMD_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign valid = valid_ff;

endmodule
